@@ rtl/salru_pkg.sv @@
// ----------------------------------------------------------------------------
// salru_pkg
// Shared codes, widths and control types for the streaming-aware LRU core.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int FUNC_W     = 2;
  localparam int SET_IDX_W  = 6;
  localparam int WAY_IDX_W  = 3;
  localparam int WLEN_W     = 9;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 8;
  localparam int M_FIELDS_W = WAY_IDX_W + 2;

  localparam int SET_CODES      = 1 << SET_IDX_W;
  localparam int PCT_SCALE      = 100;
  localparam int WLEN_RST       = 32;
  localparam int PCT_RST        = 50;
  localparam int TIME_RST       = 2;
  localparam int NEAR_LRU_STAMP = 1;

  localparam logic [FUNC_W-1:0] FN_HIT    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_INVAL  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_PERCENT  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SCAN,
    ST_EVAL,
    ST_REPLY
  } salru_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic update;
    logic scan_step;
    logic eval;
    logic load_out;
  } salru_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic query;
    logic need_eval;
    logic scan_last;
    logic out_free;
  } salru_sts_t;

endpackage

@@ rtl/streaming_aware_lru_replacement_core.sv @@
// ----------------------------------------------------------------------------
// streaming_aware_lru_replacement_core
// Timestamp LRU replacement metadata with near-LRU insertion while streaming.
// ----------------------------------------------------------------------------
// After reset the core sweeps the stamp and reuse memories one set per cycle
// with s_tready low; configuration writes are taken throughout.
// Each beat is then handled on its own: a touch, insert or invalidate
// passes through the read, update and reply steps, with an evaluation step
// added when a push fills the outcome window and the streaming phase is
// re-evaluated; a victim query adds a scan that compares one stamp of the
// set row per cycle. A result waiting in the output register holds the core
// in its reply step until m_tready takes it.
// ----------------------------------------------------------------------------
module streaming_aware_lru_replacement_core #(
  parameter int SETS       = 64,
  parameter int WAYS       = 8,
  parameter int WINDOW_MAX = 256,
  parameter int STAMP_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // func[1:0], set_index[7:2], way[10:8], zero fill
  input  logic [salru_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // victim_way[2:0], streaming[3], near_lru_insert[4], zero fill
  output logic [salru_pkg::M_TDATA_W-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import salru_pkg::*;

  salru_cmd_t            cmd;
  salru_sts_t            sts;
  logic [FUNC_W-1:0]     in_func;
  logic [SET_IDX_W-1:0]  in_set;
  logic [WAY_IDX_W-1:0]  in_way;
  logic [WAY_IDX_W-1:0]  victim_way;
  logic                  streaming;
  logic                  near_lru_insert;

  assign in_func = s_tdata[FUNC_W-1:0];
  assign in_set  = s_tdata[FUNC_W +: SET_IDX_W];
  assign in_way  = s_tdata[FUNC_W + SET_IDX_W +: WAY_IDX_W];

  assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, near_lru_insert, streaming, victim_way};

  salru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salru_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .WINDOW_MAX (WINDOW_MAX),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_set          (in_set),
    .in_way          (in_way),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .victim_way      (victim_way),
    .streaming       (streaming),
    .near_lru_insert (near_lru_insert)
  );

endmodule

@@ rtl/salru_ctrl.sv @@
// ----------------------------------------------------------------------------
// salru_ctrl
// Sequencer: clearing sweep, beat intake, metadata update, victim scan,
// phase evaluation and result hand-off.
// ----------------------------------------------------------------------------
module salru_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  salru_pkg::salru_sts_t sts,
  output salru_pkg::salru_cmd_t cmd
);
  import salru_pkg::*;

  salru_state_t state;
  salru_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        priority if (sts.query) begin
          state_next = ST_SCAN;
        end else if (sts.need_eval) begin
          state_next = ST_EVAL;
        end else begin
          state_next = ST_REPLY;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_REPLY;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_REPLY;
      end
      ST_REPLY: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/salru_dp.sv @@
// ----------------------------------------------------------------------------
// salru_dp
// Datapath: stamp and reuse row memories, outcome window, phase flag,
// time counter, victim scan and the output register.
// ----------------------------------------------------------------------------
module salru_dp #(
  parameter int SETS       = 64,
  parameter int WAYS       = 8,
  parameter int WINDOW_MAX = 256,
  parameter int STAMP_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  salru_pkg::salru_cmd_t                cmd,
  output salru_pkg::salru_sts_t                sts,
  input  logic [salru_pkg::FUNC_W-1:0]         in_func,
  input  logic [salru_pkg::SET_IDX_W-1:0]      in_set,
  input  logic [salru_pkg::WAY_IDX_W-1:0]      in_way,
  input  logic                                 cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [salru_pkg::WAY_IDX_W-1:0]      victim_way,
  output logic                                 streaming,
  output logic                                 near_lru_insert
);
  import salru_pkg::*;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int WIN_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int PROD_W = CNT_W + PCT_W;
  localparam int ROW_W  = WAYS * STAMP_BITS;

  // set index folded onto the configured set count
  logic [SET_W-1:0] set_lut [SET_CODES];
  for (genvar g = 0; g < SET_CODES; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % SETS);
  end

  logic [ROW_W-1:0]      stamp_mem  [SETS];
  logic [WAYS-1:0]       reused_mem [SETS];
  logic                  win_mem    [WINDOW_MAX];

  logic [ROW_W-1:0]      row_stamp;
  logic [WAYS-1:0]       row_reused;
  logic                  win_rd;

  logic [FUNC_W-1:0]     func_q;
  logic [SET_W-1:0]      set_q;
  logic [WAY_IDX_W-1:0]  way_q;
  logic [SET_W-1:0]      clr_cnt;

  logic [WLEN_W-1:0]     window_length;
  logic [PCT_W-1:0]      dead_percent;
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      dead_total;
  logic [WIN_AW-1:0]     wp;
  logic [WIN_AW-1:0]     rp;
  logic                  streaming_flag;
  logic [STAMP_BITS-1:0] time_now;

  logic [STAMP_BITS-1:0] best_stamp;
  logic [WAY_W-1:0]      best_way;
  logic [WAY_W-1:0]      scan_way;

  logic [31:0]           len_wide;
  logic [CNT_W-1:0]      eff_len;
  logic                  way_ok;
  logic [WAY_W-1:0]      wi;
  logic [STAMP_BITS-1:0] stamp_cur;
  logic                  reused_cur;
  logic [STAMP_BITS-1:0] stamp_new;
  logic                  reused_new;
  logic                  row_wr;
  logic                  do_push;
  logic                  push_dead;
  logic                  pop;
  logic [CNT_W-1:0]      fill_push;
  logic [ROW_W-1:0]      row_stamp_new;
  logic [WAYS-1:0]       row_reused_new;
  logic [STAMP_BITS-1:0] scan_stamp;
  logic                  near_now;
  logic [PROD_W-1:0]     dead_scaled;
  logic [PROD_W-1:0]     thresh_scaled;

  always_comb begin
    priority if (window_length == '0) begin
      len_wide = 32'd1;
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      len_wide = 32'(WINDOW_MAX);
    end else begin
      len_wide = 32'(window_length);
    end
    eff_len = CNT_W'(len_wide);
  end

  assign near_now = streaming_flag && (fill == eff_len);
  assign way_ok   = 32'(way_q) < 32'(WAYS);
  assign wi       = WAY_W'(32'(way_q));

  always_comb begin
    stamp_cur      = row_stamp[wi*STAMP_BITS +: STAMP_BITS];
    reused_cur     = row_reused[wi];
    stamp_new      = stamp_cur;
    reused_new     = reused_cur;
    do_push        = 1'b0;
    push_dead      = 1'b0;
    unique case (func_q)
      FN_HIT: begin
        do_push    = !reused_cur;
        reused_new = 1'b1;
        stamp_new  = time_now;
      end
      FN_INSERT: begin
        reused_new = 1'b0;
        stamp_new  = near_now ? STAMP_BITS'(NEAR_LRU_STAMP) : time_now;
      end
      FN_INVAL: begin
        do_push    = (stamp_cur != '0) && !reused_cur;
        push_dead  = 1'b1;
        reused_new = 1'b0;
        stamp_new  = '0;
      end
      FN_QUERY: begin
      end
      default: begin
      end
    endcase
    row_wr = way_ok && (func_q != FN_QUERY);
    if (!row_wr) begin
      do_push = 1'b0;
    end
    row_stamp_new                               = row_stamp;
    row_stamp_new[wi*STAMP_BITS +: STAMP_BITS]  = stamp_new;
    row_reused_new                              = row_reused;
    row_reused_new[wi]                          = reused_new;
  end

  assign pop       = fill == eff_len;
  assign fill_push = pop ? fill : fill + 1'b1;

  assign scan_stamp    = row_stamp[scan_way*STAMP_BITS +: STAMP_BITS];
  assign dead_scaled   = PROD_W'(dead_total) * PROD_W'(PCT_SCALE);
  assign thresh_scaled = PROD_W'(dead_percent) * PROD_W'(eff_len);

  assign sts.clr_last  = clr_cnt == SET_W'(SETS - 1);
  assign sts.query     = func_q == FN_QUERY;
  assign sts.need_eval = do_push && (fill_push == eff_len);
  assign sts.scan_last = scan_way == WAY_W'(WAYS - 1);
  assign sts.out_free  = !m_tvalid || m_tready;

  // row memories
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      stamp_mem[clr_cnt]  <= '0;
      reused_mem[clr_cnt] <= '0;
    end else if (cmd.update && row_wr) begin
      stamp_mem[set_q]  <= row_stamp_new;
      reused_mem[set_q] <= row_reused_new;
    end
    row_stamp  <= stamp_mem[set_q];
    row_reused <= reused_mem[set_q];
  end

  // outcome window
  always_ff @(posedge clk) begin
    if (cmd.update && do_push) begin
      win_mem[wp] <= push_dead;
    end
    win_rd <= win_mem[rp];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= in_func;
      set_q  <= set_lut[in_set];
      way_q  <= in_way;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WLEN_W'(WLEN_RST);
      dead_percent   <= PCT_W'(PCT_RST);
      fill           <= '0;
      dead_total     <= '0;
      wp             <= '0;
      rp             <= '0;
      streaming_flag <= 1'b0;
      time_now       <= STAMP_BITS'(TIME_RST);
    end else begin
      if (cfg_we && (cfg_index == CFG_WINDOW_LENGTH)) begin
        window_length <= cfg_data[WLEN_W-1:0];
        fill          <= '0;
        dead_total    <= '0;
        wp            <= '0;
        rp            <= '0;
      end else if (cmd.update && do_push) begin
        fill       <= fill_push;
        dead_total <= dead_total - CNT_W'(pop & win_rd) + CNT_W'(push_dead);
        wp         <= (wp == WIN_AW'(WINDOW_MAX - 1)) ? '0 : wp + 1'b1;
        if (pop) begin
          rp <= (rp == WIN_AW'(WINDOW_MAX - 1)) ? '0 : rp + 1'b1;
        end
      end
      if (cfg_we && (cfg_index == CFG_DEAD_PERCENT)) begin
        dead_percent <= cfg_data[PCT_W-1:0];
      end
      if (cmd.eval) begin
        streaming_flag <= dead_scaled >= thresh_scaled;
      end
      if (cmd.update && (time_now != '1)) begin
        time_now <= time_now + 1'b1;
      end
    end
  end

  // victim scan over the registered row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best_way <= '0;
    end else if (cmd.update) begin
      best_stamp <= row_stamp[STAMP_BITS-1:0];
      best_way   <= '0;
      scan_way   <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (scan_stamp < best_stamp) begin
        best_stamp <= scan_stamp;
        best_way   <= scan_way;
      end
      scan_way <= scan_way + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      victim_way      <= WAY_IDX_W'(32'(best_way));
      streaming       <= streaming_flag;
      near_lru_insert <= near_now;
    end
  end

endmodule
